>>> design/rmts_pkg.sv
// rmts_pkg: shared constants and types of the rate-monotonic tick scheduler
// no dependencies; imported by every module of the block
package rmts_pkg;

    localparam int CFG_TASKS     = 4;
    localparam int NUM_TASKS_DEF = 4;
    localparam int TASK_LIMIT    = 8;

    localparam int DATA_W = 16;
    localparam int TASK_W = 2;
    localparam int MASK_W = CFG_TASKS;
    localparam int PICK_W = $clog2(TASK_LIMIT);

    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = $clog2(2 * CFG_TASKS);
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    // register map: periods first, then execution times
    localparam int REG_PERIOD_BASE = 0;
    localparam int REG_EXEC_BASE   = CFG_TASKS;

    typedef struct packed {
        logic              found;
        logic [PICK_W-1:0] index;
    } t_pick;

endpackage

>>> design/rmts_pick.sv
// rmts_pick: shortest-period selection among tasks with work left
// depends on rmts_pkg
module rmts_pick #(
    parameter int NUM_TASKS = rmts_pkg::NUM_TASKS_DEF
) (
    input  logic [NUM_TASKS-1:0]        i_busy,
    input  logic [rmts_pkg::DATA_W-1:0] i_period [NUM_TASKS],
    output rmts_pkg::t_pick             o_pick
);
    import rmts_pkg::*;

    always_comb begin
        logic [DATA_W-1:0] best;
        t_pick             sel;
        best      = '1;
        sel.found = 1'b0;
        sel.index = '0;
        // strict compare keeps the lower index on ties
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (i_busy[i] && (!sel.found || (i_period[i] < best))) begin
                sel.found = 1'b1;
                sel.index = PICK_W'(i);
                best      = i_period[i];
            end
        end
        o_pick = sel;
    end

endmodule

>>> design/rate_monotonic_tick_scheduler_unit.sv
// rate_monotonic_tick_scheduler_unit: top level of the tick scheduler
// depends on rmts_pkg and rmts_pick
//
// usage
// - input channel (i_in_valid / o_in_ready) carries one tick per transfer;
//   i_restart reloads all tasks and clears all phases before that tick
// - output channel (o_out_valid / i_out_ready) returns one result per tick:
//   running task, idle flag, completion flag and release mask
// - the user must write periods and execution times over the apb-style
//   port only while no tick is in flight; the block does not enforce it;
//   reads return the stored values
// - throughput: one tick per cycle while the receiver does not stall; a
//   tick passes the tick register, the per-task counter update and the
//   priority compare, and then the result register
// - when the receiver stalls, the result holds and one more tick waits in
//   the tick register; o_in_ready drops only while both are full
// - reset clears counters, config registers (period 1, exec time 0) and
//   both valid flags
module rate_monotonic_tick_scheduler_unit #(
    parameter int NUM_TASKS = rmts_pkg::NUM_TASKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_restart,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rmts_pkg::TASK_W-1:0]     o_running_task,
    output logic                            o_idle,
    output logic                            o_completed,
    output logic [rmts_pkg::MASK_W-1:0]     o_released_mask,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rmts_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rmts_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rmts_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import rmts_pkg::*;

    logic [DATA_W-1:0] r_period [NUM_TASKS];
    logic [DATA_W-1:0] r_exec   [NUM_TASKS];
    logic [DATA_W-1:0] r_rem    [NUM_TASKS];
    logic [DATA_W-1:0] r_phase  [NUM_TASKS];
    logic [DATA_W-1:0] n_rem    [NUM_TASKS];
    logic [DATA_W-1:0] n_phase  [NUM_TASKS];
    logic [DATA_W-1:0] w_eff    [NUM_TASKS];
    logic [DATA_W-1:0] w_ph0    [NUM_TASKS];
    logic [DATA_W-1:0] w_rm1    [NUM_TASKS];
    logic [NUM_TASKS-1:0] w_busy;
    logic [NUM_TASKS-1:0] w_rel;
    logic [MASK_W-1:0]    n_mask;
    logic                 n_done;

    logic r_in_valid;
    logic r_in_restart;
    logic r_out_valid;
    logic [TASK_W-1:0] r_running_task;
    logic              r_idle;
    logic              r_completed;
    logic [MASK_W-1:0] r_released_mask;

    logic                 w_fire;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;
    t_pick                w_pick;

    // config port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[APB_ADDR_W-1:2];

    always_comb begin
        prdata = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (i < CFG_TASKS) begin
                if (w_idx == REG_IDX_W'(REG_PERIOD_BASE + i)) begin
                    prdata = APB_DATA_W'(r_period[i]);
                end
                if (w_idx == REG_IDX_W'(REG_EXEC_BASE + i)) begin
                    prdata = APB_DATA_W'(r_exec[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_period[i] <= DATA_W'(1);
                r_exec[i]   <= '0;
            end
        end else if (w_wr) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                if (i < CFG_TASKS) begin
                    if (w_idx == REG_IDX_W'(REG_PERIOD_BASE + i)) begin
                        r_period[i] <= pwdata[DATA_W-1:0];
                    end
                    if (w_idx == REG_IDX_W'(REG_EXEC_BASE + i)) begin
                        r_exec[i] <= pwdata[DATA_W-1:0];
                    end
                end
            end
        end
    end

    // handshake
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_restart <= i_restart;
        end
    end

    // per-task release and phase logic
    always_comb begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            w_eff[i] = (r_period[i] == '0) ? DATA_W'(1) : r_period[i];
            w_ph0[i] = r_in_restart ? '0 : r_phase[i];
            w_rm1[i] = r_in_restart ? r_exec[i] : r_rem[i];
            w_rel[i] = 1'b0;
            if ((w_ph0[i] == '0) && (w_rm1[i] == '0)) begin
                w_rm1[i] = r_exec[i];
                w_rel[i] = (r_exec[i] != '0) && (i < CFG_TASKS);
            end
            w_busy[i] = (w_rm1[i] != '0);
        end
    end

    rmts_pick #(
        .NUM_TASKS (NUM_TASKS)
    ) u_pick (
        .i_busy   (w_busy),
        .i_period (w_eff),
        .o_pick   (w_pick)
    );

    always_comb begin
        logic [DATA_W:0] nxt;
        logic            sel;
        n_done = 1'b0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            sel      = w_pick.found && (w_pick.index == PICK_W'(i));
            n_rem[i] = w_rm1[i] - DATA_W'(sel);
            if (sel && (w_rm1[i] == DATA_W'(1))) begin
                n_done = 1'b1;
            end
            nxt        = {1'b0, w_ph0[i]} + (DATA_W + 1)'(1);
            n_phase[i] = (nxt >= {1'b0, w_eff[i]}) ? '0 : nxt[DATA_W-1:0];
        end
    end

    for (genvar g = 0; g < MASK_W; g++) begin : g_mask
        if (g < NUM_TASKS) begin : g_on
            assign n_mask[g] = w_rel[g];
        end else begin : g_off
            assign n_mask[g] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_rem[i]   <= '0;
                r_phase[i] <= '0;
            end
        end else if (w_fire) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_rem[i]   <= n_rem[i];
                r_phase[i] <= n_phase[i];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_running_task  <= w_pick.found ? TASK_W'(w_pick.index) : '0;
            r_idle          <= !w_pick.found;
            r_completed     <= n_done;
            r_released_mask <= n_mask;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_running_task  = r_running_task;
    assign o_idle          = r_idle;
    assign o_completed     = r_completed;
    assign o_released_mask = r_released_mask;

endmodule

>>> design/rmts_checker.sv
// rmts_checker: port-level assertions for the tick scheduler, with its bind
// depends on rmts_pkg; attached to rate_monotonic_tick_scheduler_unit
module rmts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [rmts_pkg::TASK_W-1:0]   o_running_task,
    input logic                          o_idle,
    input logic                          o_completed,
    input logic [rmts_pkg::MASK_W-1:0]   o_released_mask
);
    import rmts_pkg::*;

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped while stalled");

    // idle tick reports task 0 and no completion
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_idle) |-> (o_running_task == '0 && !o_completed))
        else $error("idle tick with task or completion");

    // a released task always has work, so the tick cannot be idle
    a_rel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_released_mask != '0)) |-> !o_idle)
        else $error("release on an idle tick");

endmodule

bind rate_monotonic_tick_scheduler_unit rmts_checker u_rmts_checker (.*);
